/* rtl/bbs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bbs_pkg
// Shared types and constants of the battery beacon scheduler.
// ----------------------------------------------------------------------------
package bbs_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVITY_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET_TIME      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REFRESH         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DELAY   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_CHARGING   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_DISCHARGE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_USAGE   = 3'd7;

    localparam logic [31:0] RST_ACTIVITY_WINDOW = 32'd60000;
    localparam logic [31:0] RST_QUIET_TIME      = 32'd200;
    localparam logic [31:0] RST_MIN_INTERVAL    = 32'd5000;
    localparam logic [31:0] RST_REFRESH         = 32'd300000;
    localparam logic [31:0] RST_RELEASE_DELAY   = 32'd20;

    localparam logic [2:0]  LINK_CONNECTED = 3'd1;
    localparam logic [2:0]  LINK_RESET     = 3'd0;
    localparam logic [7:0]  PCT_UNKNOWN    = 8'hFF;
    localparam logic [7:0]  PCT_MAX        = 8'd100;
    localparam logic [31:0] HALF_RANGE     = 32'h7FFF_FFFF;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_PRESS   = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_SAMPLE  = 2'd3
    } req_kind_t;

    // classified event as it sits in the queue
    typedef struct packed {
        req_kind_t   kind;
        logic [31:0] now_ms;
        logic [6:0]  pct;
        logic        charging;
        logic        link_ready;
        logic [2:0]  link_state;
    } item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

    typedef struct packed {
        logic pop;
        logic emit;
    } back_stat_t;

endpackage
`default_nettype wire

/* rtl/battery_beacon_scheduler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// battery_beacon_scheduler
// Decides when to send a battery-level beacon or its release code.
// ----------------------------------------------------------------------------
// Takes one time-stamped event per clock while the queue has room (tick, key
// press, key release, battery sample) and answers with at most one code word
// per tick: a beacon base+percent (tuser 0) or the release code (tuser 1).
// Events pass through a queue of QUEUE_DEPTH words into the state update,
// which retires one word per cycle unless the result register is stalled;
// each result is registered once its event has left the queue. While the
// result register is held by m_tready low, the queue keeps taking events
// until it is full. Configuration writes are taken at any time, and should
// be made only while no events are in flight.
module battery_beacon_scheduler #(
    parameter int QUEUE_DEPTH = bbs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bbs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [bbs_pkg::CFG_DATA_W-1:0]      cfg_data,
    // event input
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // now_ms[31:0], battery_pct[39:32], usb_power[40], on_wireless[41],
    // link_state[44:42], zero[47:45]
    input  wire logic [bbs_pkg::IN_TDATA_W-1:0]      s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]                          s_tuser,
    // result output
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // usage_code[15:0]
    output logic [bbs_pkg::OUT_TDATA_W-1:0]          m_tdata,
    // is_release[0]
    output logic                                     m_tuser
);

    bbs_pkg::queue_stat_t q_stat;
    bbs_pkg::back_stat_t  b_stat;
    bbs_pkg::item_t       wr_item, rd_item;
    logic                 push;

    assign cfg_ready = 1'b1;

    bbs_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .push     (push),
        .item     (wr_item)
    );

    bbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_item (wr_item),
        .pop     (b_stat.pop),
        .rd_item (rd_item),
        .stat    (q_stat)
    );

    bbs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .item      (rd_item),
        .stat      (b_stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef ASSERT_OFF
    // the back end never retires from an empty queue
    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        b_stat.pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // a waiting word is retired whenever the result slot can take a word
    a_no_idle_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (!q_stat.empty && (!m_tvalid || m_tready)) |-> b_stat.pop)
        else $error("back end stalled with free result slot");

    // a result is only produced while retiring a word
    a_emit_on_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        b_stat.emit |-> b_stat.pop)
        else $error("result without retired word");

    // reset leaves no result and an empty queue behind
    a_reset_clean: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && q_stat.empty))
        else $error("state left after reset");
`endif

endmodule
`default_nettype wire

/* rtl/bbs_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bbs_front
// Intake: unpacks the input word, clamps the percent, flags a usable link
// and pushes the classified event into the queue.
// ----------------------------------------------------------------------------
module bbs_front (
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [bbs_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic [1:0]                      s_tuser,
    input  wire bbs_pkg::queue_stat_t            q_stat,
    output logic                                 push,
    output bbs_pkg::item_t                       item
);

    logic [7:0] raw_pct;
    logic       wireless;

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && !q_stat.full;

    assign raw_pct  = s_tdata[39:32];
    assign wireless = s_tdata[41];

    always_comb begin
        item.kind       = bbs_pkg::req_kind_t'(s_tuser);
        item.now_ms     = s_tdata[31:0];
        item.pct        = (raw_pct > bbs_pkg::PCT_MAX) ? bbs_pkg::PCT_MAX[6:0] : raw_pct[6:0];
        item.charging   = s_tdata[40];
        item.link_state = s_tdata[44:42];
        item.link_ready = wireless && (s_tdata[44:42] == bbs_pkg::LINK_CONNECTED);
    end

endmodule
`default_nettype wire

/* rtl/bbs_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bbs_queue
// Short first-in first-out queue of classified events between intake and
// the state update.
// ----------------------------------------------------------------------------
module bbs_queue #(
    parameter int DEPTH = bbs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire bbs_pkg::item_t       wr_item,
    input  wire logic                 pop,
    output bbs_pkg::item_t            rd_item,
    output bbs_pkg::queue_stat_t      stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bbs_pkg::item_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign rd_item    = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule
`default_nettype wire

/* rtl/bbs_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bbs_back
// State update: holds configuration and scheduler state, retires one queued
// event per cycle while the result slot is free and registers the code word.
// ----------------------------------------------------------------------------
module bbs_back (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    input  wire logic [bbs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [bbs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire bbs_pkg::queue_stat_t                q_stat,
    input  wire bbs_pkg::item_t                      item,
    output bbs_pkg::back_stat_t                      stat,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [bbs_pkg::OUT_TDATA_W-1:0]          m_tdata,
    output logic                                     m_tuser
);

    // configuration
    logic [31:0] window_reg, quiet_reg, min_int_reg, refresh_reg, rel_delay_reg;
    logic [15:0] base_chg_reg, base_dis_reg, rel_usage_reg;

    // scheduler state
    logic        sample_seen_reg, sample_seen_next;
    logic        act_seen_reg, act_seen_next;
    logic [31:0] last_act_reg, last_act_next;
    logic [7:0]  held_reg, held_next;
    logic [31:0] last_send_reg, last_send_next;
    logic        sent_once_reg, sent_once_next;
    logic [7:0]  last_value_reg, last_value_next;
    logic        last_chg_reg, last_chg_next;
    logic        dirty_reg, dirty_next;
    logic [31:0] rel_time_reg, rel_time_next;
    logic        rel_wait_reg, rel_wait_next;
    logic [2:0]  prev_link_reg, prev_link_next;

    // result register
    logic        m_valid_reg, m_valid_next;
    logic [15:0] m_code_reg;
    logic        m_rel_reg;

    logic        pop, emit, emit_rel;
    logic [15:0] code;
    logic        link_chg, reconnect, link_drop;
    logic        eff_sent_once, eff_dirty, eff_rel_wait;
    logic [7:0]  eff_last_value;
    logic [31:0] idle, since, rel_age;
    logic        rel_due, beacon_ok, change_ok, send;

    assign pop       = !q_stat.empty && (!m_valid_reg || m_tready);
    assign stat.pop  = pop;
    assign stat.emit = emit;

    assign link_chg  = (item.link_state != prev_link_reg);
    assign reconnect = link_chg && (item.link_state == bbs_pkg::LINK_CONNECTED);
    assign link_drop = link_chg && !reconnect;

    assign eff_sent_once  = reconnect ? 1'b0 : sent_once_reg;
    assign eff_last_value = reconnect ? bbs_pkg::PCT_UNKNOWN : last_value_reg;
    assign eff_dirty      = reconnect || dirty_reg;
    assign eff_rel_wait   = link_drop ? 1'b0 : rel_wait_reg;

    assign idle    = item.now_ms - last_act_reg;
    assign since   = item.now_ms - last_send_reg;
    assign rel_age = item.now_ms - rel_time_reg;
    assign rel_due = (rel_age < bbs_pkg::HALF_RANGE);

    assign beacon_ok = item.link_ready && act_seen_reg && (idle < window_reg)
                     && (held_reg == '0) && (idle > quiet_reg) && sample_seen_reg;

    // minimum interval passed and value or power source changed, or refresh ran out
    assign change_ok = (since >= min_int_reg)
                     && (({1'b0, item.pct} != eff_last_value)
                         || (item.charging != last_chg_reg)
                         || (since >= refresh_reg));

    assign send = beacon_ok && (eff_dirty || !eff_sent_once || change_ok);

    always_comb begin
        sample_seen_next = sample_seen_reg;
        act_seen_next    = act_seen_reg;
        last_act_next    = last_act_reg;
        held_next        = held_reg;
        last_send_next   = last_send_reg;
        sent_once_next   = sent_once_reg;
        last_value_next  = last_value_reg;
        last_chg_next    = last_chg_reg;
        dirty_next       = dirty_reg;
        rel_time_next    = rel_time_reg;
        rel_wait_next    = rel_wait_reg;
        prev_link_next   = prev_link_reg;
        emit             = 1'b0;
        emit_rel         = 1'b0;
        code             = '0;
        if (pop) begin
            unique case (item.kind)
                bbs_pkg::REQ_PRESS, bbs_pkg::REQ_RELEASE: begin
                    last_act_next = item.now_ms;
                    act_seen_next = 1'b1;
                    if (item.kind == bbs_pkg::REQ_PRESS) begin
                        if (held_reg != 8'hFF) held_next = held_reg + 8'd1;
                    end else if (held_reg != '0) begin
                        held_next = held_reg - 8'd1;
                    end
                end
                bbs_pkg::REQ_SAMPLE: begin
                    sample_seen_next = 1'b1;
                    dirty_next       = 1'b1;
                end
                bbs_pkg::REQ_TICK: begin
                    prev_link_next  = item.link_state;
                    sent_once_next  = eff_sent_once;
                    last_value_next = eff_last_value;
                    dirty_next      = eff_dirty;
                    rel_wait_next   = eff_rel_wait;
                    if (eff_rel_wait) begin
                        // pending release blocks beacons until it is retired
                        if (rel_due) begin
                            rel_wait_next = 1'b0;
                            emit          = item.link_ready;
                            emit_rel      = 1'b1;
                            code          = rel_usage_reg;
                        end
                    end else if (send) begin
                        emit            = 1'b1;
                        code            = (item.charging ? base_chg_reg : base_dis_reg)
                                        + {9'd0, item.pct};
                        dirty_next      = 1'b0;
                        last_send_next  = item.now_ms;
                        sent_once_next  = 1'b1;
                        last_value_next = {1'b0, item.pct};
                        last_chg_next   = item.charging;
                        rel_time_next   = item.now_ms + rel_delay_reg;
                        rel_wait_next   = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg    <= bbs_pkg::RST_ACTIVITY_WINDOW;
            quiet_reg     <= bbs_pkg::RST_QUIET_TIME;
            min_int_reg   <= bbs_pkg::RST_MIN_INTERVAL;
            refresh_reg   <= bbs_pkg::RST_REFRESH;
            rel_delay_reg <= bbs_pkg::RST_RELEASE_DELAY;
            base_chg_reg  <= '0;
            base_dis_reg  <= '0;
            rel_usage_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bbs_pkg::REG_ACTIVITY_WINDOW: window_reg    <= cfg_data;
                bbs_pkg::REG_QUIET_TIME:      quiet_reg     <= cfg_data;
                bbs_pkg::REG_MIN_INTERVAL:    min_int_reg   <= cfg_data;
                bbs_pkg::REG_REFRESH:         refresh_reg   <= cfg_data;
                bbs_pkg::REG_RELEASE_DELAY:   rel_delay_reg <= cfg_data;
                bbs_pkg::REG_BASE_CHARGING:   base_chg_reg  <= cfg_data[15:0];
                bbs_pkg::REG_BASE_DISCHARGE:  base_dis_reg  <= cfg_data[15:0];
                bbs_pkg::REG_RELEASE_USAGE:   rel_usage_reg <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_seen_reg <= 1'b0;
            act_seen_reg    <= 1'b0;
            last_act_reg    <= '0;
            held_reg        <= '0;
            last_send_reg   <= '0;
            sent_once_reg   <= 1'b0;
            last_value_reg  <= bbs_pkg::PCT_UNKNOWN;
            last_chg_reg    <= 1'b0;
            dirty_reg       <= 1'b0;
            rel_time_reg    <= '0;
            rel_wait_reg    <= 1'b0;
            prev_link_reg   <= bbs_pkg::LINK_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            sample_seen_reg <= sample_seen_next;
            act_seen_reg    <= act_seen_next;
            last_act_reg    <= last_act_next;
            held_reg        <= held_next;
            last_send_reg   <= last_send_next;
            sent_once_reg   <= sent_once_next;
            last_value_reg  <= last_value_next;
            last_chg_reg    <= last_chg_next;
            dirty_reg       <= dirty_next;
            rel_time_reg    <= rel_time_next;
            rel_wait_reg    <= rel_wait_next;
            prev_link_reg   <= prev_link_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_code_reg <= code;
            m_rel_reg  <= emit_rel;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_code_reg;
    assign m_tuser  = m_rel_reg;

endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the battery beacon scheduler.
// ----------------------------------------------------------------------------
// Drives time-stamped events with bursty gaps, stalls the result side on
// changing patterns, and compares every result word with an in-bench
// predictor of the beacon and release decisions. The run visits several
// register settings: defaults, small intervals, maximum window and bases,
// all-zero, random ones, and a held-key saturation sweep.
module tb;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 80;

    typedef struct packed {
        logic [15:0] code;
        logic        rel;
    } beacon_word_t;

    class beacon_tracker;
        logic [31:0] window_ms, quiet_ms, min_gap_ms, refresh_ms, rel_delay_ms;
        logic [15:0] base_chg, base_dis, rel_code;
        logic        sample_seen, act_seen, sent_once, last_chg, dirty, rel_wait;
        logic [31:0] act_time, last_send, rel_time;
        logic [7:0]  held, last_pct;
        logic [2:0]  prev_link;
        beacon_word_t expected_words[$];
        int errors, reported, beacons, releases;

        function new();
            window_ms = bbs_pkg::RST_ACTIVITY_WINDOW;
            quiet_ms = bbs_pkg::RST_QUIET_TIME;
            min_gap_ms = bbs_pkg::RST_MIN_INTERVAL;
            refresh_ms = bbs_pkg::RST_REFRESH;
            rel_delay_ms = bbs_pkg::RST_RELEASE_DELAY;
            base_chg = '0;
            base_dis = '0;
            rel_code = '0;
            sample_seen = 0;
            act_seen = 0;
            sent_once = 0;
            last_chg = 0;
            dirty = 0;
            rel_wait = 0;
            act_time = '0;
            last_send = '0;
            rel_time = '0;
            held = '0;
            last_pct = bbs_pkg::PCT_UNKNOWN;
            prev_link = bbs_pkg::LINK_RESET;
            errors = 0;
            reported = 0;
            beacons = 0;
            releases = 0;
        endfunction

        function void configure(logic [bbs_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                bbs_pkg::REG_ACTIVITY_WINDOW: window_ms = data;
                bbs_pkg::REG_QUIET_TIME:      quiet_ms = data;
                bbs_pkg::REG_MIN_INTERVAL:    min_gap_ms = data;
                bbs_pkg::REG_REFRESH:         refresh_ms = data;
                bbs_pkg::REG_RELEASE_DELAY:   rel_delay_ms = data;
                bbs_pkg::REG_BASE_CHARGING:   base_chg = data[15:0];
                bbs_pkg::REG_BASE_DISCHARGE:  base_dis = data[15:0];
                bbs_pkg::REG_RELEASE_USAGE:   rel_code = data[15:0];
                default: ;
            endcase
        endfunction

        function void predict_event(bbs_pkg::req_kind_t kind, logic [31:0] now,
                                    logic [7:0] raw, logic chg, logic wl,
                                    logic [2:0] link);
            logic        ready;
            logic        send;
            logic [31:0] idle;
            logic [31:0] since;
            logic [7:0]  pct;
            beacon_word_t w;
            if (kind == bbs_pkg::REQ_PRESS || kind == bbs_pkg::REQ_RELEASE) begin
                act_time = now;
                act_seen = 1;
                if (kind == bbs_pkg::REQ_PRESS) begin
                    if (held != 8'hFF) held = held + 8'd1;
                end else if (held != 8'd0) begin
                    held = held - 8'd1;
                end
                return;
            end
            if (kind == bbs_pkg::REQ_SAMPLE) begin
                sample_seen = 1;
                dirty = 1;
                return;
            end
            // link tracking happens on ticks only
            if (link != prev_link) begin
                if (link == bbs_pkg::LINK_CONNECTED) begin
                    sent_once = 0;
                    last_pct = bbs_pkg::PCT_UNKNOWN;
                    dirty = 1;
                end else begin
                    rel_wait = 0;
                end
                prev_link = link;
            end
            ready = wl && (link == bbs_pkg::LINK_CONNECTED);
            if (rel_wait) begin
                if ((now - rel_time) >= bbs_pkg::HALF_RANGE) return;
                rel_wait = 0;
                if (!ready) return;
                w.code = rel_code;
                w.rel = 1'b1;
                expected_words.push_back(w);
                return;
            end
            if (!ready) return;
            idle = now - act_time;
            if (!act_seen || idle >= window_ms) return;
            if (held != 8'd0 || idle <= quiet_ms) return;
            if (!sample_seen) return;
            pct = (raw > bbs_pkg::PCT_MAX) ? bbs_pkg::PCT_MAX : raw;
            if (dirty || !sent_once) begin
                send = 1;
            end else begin
                since = now - last_send;
                if (since < min_gap_ms) send = 0;
                else if (pct != last_pct || chg != last_chg) send = 1;
                else send = (since >= refresh_ms);
            end
            if (!send) return;
            dirty = 0;
            w.code = (chg ? base_chg : base_dis) + {8'd0, pct};
            w.rel = 1'b0;
            expected_words.push_back(w);
            last_send = now;
            sent_once = 1;
            last_pct = pct;
            last_chg = chg;
            rel_time = now + rel_delay_ms;
            rel_wait = 1;
        endfunction

        function void check_result(logic [15:0] code, logic rel);
            beacon_word_t w;
            if (expected_words.size() == 0) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("unexpected word: code %h release %b", code, rel);
                end
                return;
            end
            w = expected_words.pop_front();
            if (rel) releases++;
            else beacons++;
            if (code !== w.code || rel !== w.rel) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    if (code !== w.code)
                        $display("code mismatch: expected %h got %h", w.code, code);
                    if (rel !== w.rel)
                        $display("release flag mismatch: expected %b got %b", w.rel, rel);
                end
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [bbs_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [bbs_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [bbs_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic [1:0]                      s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [bbs_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tuser;

    beacon_tracker tracker = new();

    int          cycles = 0;
    int          items_sent = 0;
    int          cfg_writes = 0;
    int          burst_left = 0;
    int          pressed_count = 0;
    bit          hold_request = 0;
    logic [31:0] clock_ms = '0;
    logic [7:0]  cur_pct = 8'd50;
    logic        cur_chg = 1'b0;

    battery_beacon_scheduler uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // receiver: changing stall patterns plus one long hold-off on request
    initial begin : receiver
        int hold_left;
        int mode;
        int mode_left;
        hold_left = 0;
        mode = 0;
        mode_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_left = HOLD_CYCLES;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_result(m_tdata, m_tuser);
    end

    initial begin : watchdog
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("*** FAILED ***");
        $finish;
    end

    // called at a falling edge; leaves cfg_valid high for the next write
    task cfg_write(logic [bbs_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.configure(idx, data);
        cfg_writes++;
        @(negedge aclk);
    endtask

    task set_config(logic [31:0] window, logic [31:0] quiet, logic [31:0] min_gap,
                    logic [31:0] refresh, logic [31:0] rel_delay, logic [15:0] b_chg,
                    logic [15:0] b_dis, logic [15:0] r_code);
        cfg_write(bbs_pkg::REG_ACTIVITY_WINDOW, window);
        cfg_write(bbs_pkg::REG_QUIET_TIME, quiet);
        cfg_write(bbs_pkg::REG_MIN_INTERVAL, min_gap);
        cfg_write(bbs_pkg::REG_REFRESH, refresh);
        cfg_write(bbs_pkg::REG_RELEASE_DELAY, rel_delay);
        cfg_write(bbs_pkg::REG_BASE_CHARGING, {16'd0, b_chg});
        cfg_write(bbs_pkg::REG_BASE_DISCHARGE, {16'd0, b_dis});
        cfg_write(bbs_pkg::REG_RELEASE_USAGE, {16'd0, r_code});
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task drive_event(bbs_pkg::req_kind_t kind, logic [31:0] now, logic [7:0] pct,
                     logic chg, logic wl, logic [2:0] link);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, link, wl, chg, pct, now};
        s_tuser <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.predict_event(kind, now, pct, chg, wl, link);
        items_sent++;
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
    endtask

    task stop_offering();
        if (s_tvalid) s_tvalid <= 1'b0;
    endtask

    // wait for every expected word, then let in-flight events retire
    task drain();
        stop_offering();
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task random_event(int step_max);
        int                 r;
        bbs_pkg::req_kind_t kind;
        logic               wl;
        logic [2:0]         link;
        logic [31:0]        now;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 49) == 0) clock_ms = clock_ms + $urandom;
        else clock_ms = clock_ms + $urandom_range(0, step_max);
        if ($urandom_range(0, 1) == 0) cur_pct = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0) cur_chg = ~cur_chg;
        wl = ($urandom_range(0, 99) < 92);
        link = ($urandom_range(0, 99) < 85) ? bbs_pkg::LINK_CONNECTED
                                             : 3'($urandom_range(0, 7));
        now = clock_ms;
        if (r < 45) begin
            kind = bbs_pkg::REQ_TICK;
        end else if (r < 57) begin
            kind = bbs_pkg::REQ_SAMPLE;
        end else if (r < 72) begin
            kind = (pressed_count > 0) ? bbs_pkg::REQ_RELEASE : bbs_pkg::REQ_PRESS;
        end else if (r < 78) begin
            kind = bbs_pkg::REQ_PRESS;
        end else if (r < 84) begin
            kind = bbs_pkg::REQ_RELEASE;
        end else begin
            // noise word with random kind, wireless flag and link, sometimes a random time
            kind = bbs_pkg::req_kind_t'($urandom_range(0, 3));
            wl = 1'($urandom_range(0, 1));
            link = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 3) == 0) now = $urandom;
        end
        if (kind == bbs_pkg::REQ_PRESS && pressed_count < 255) pressed_count++;
        if (kind == bbs_pkg::REQ_RELEASE && pressed_count > 0) pressed_count--;
        drive_event(kind, now, cur_pct, cur_chg, wl, link);
    endtask

    task run_random(int count, int step_max);
        for (int i = 0; i < count; i++) random_event(step_max);
    endtask

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part under reset settings
        drive_event(bbs_pkg::REQ_TICK,    32'd0,    8'd0,   1'b0, 1'b0,
                    bbs_pkg::LINK_RESET);
        drive_event(bbs_pkg::REQ_TICK,    32'd10,   8'd0,   1'b0, 1'b1,
                    bbs_pkg::LINK_CONNECTED);
        drive_event(bbs_pkg::REQ_SAMPLE,  32'd20,   8'd255, 1'b1, 1'b1,
                    bbs_pkg::LINK_CONNECTED);
        drive_event(bbs_pkg::REQ_PRESS,   32'd100,  8'd255, 1'b1, 1'b1,
                    bbs_pkg::LINK_CONNECTED);
        drive_event(bbs_pkg::REQ_RELEASE, 32'd150,  8'd255, 1'b1, 1'b1,
                    bbs_pkg::LINK_CONNECTED);
        drive_event(bbs_pkg::REQ_TICK,    32'd300,  8'd255, 1'b1, 1'b1,
                    bbs_pkg::LINK_CONNECTED);
        drive_event(bbs_pkg::REQ_TICK,    32'd351,  8'd255, 1'b1, 1'b1,
                    bbs_pkg::LINK_CONNECTED);
        drive_event(bbs_pkg::REQ_TICK,    32'd360,  8'd255, 1'b1, 1'b1,
                    bbs_pkg::LINK_CONNECTED);
        drive_event(bbs_pkg::REQ_TICK,    32'd371,  8'd255, 1'b1, 1'b1,
                    bbs_pkg::LINK_CONNECTED);
        drive_event(bbs_pkg::REQ_RELEASE, 32'd400,  8'd255, 1'b1, 1'b1,
                    bbs_pkg::LINK_CONNECTED);
        drive_event(bbs_pkg::REQ_SAMPLE,  32'd500,  8'd0,   1'b0, 1'b1,
                    bbs_pkg::LINK_CONNECTED);
        drive_event(bbs_pkg::REQ_TICK,    32'd601,  8'd0,   1'b0, 1'b0,
                    bbs_pkg::LINK_CONNECTED);
        drive_event(bbs_pkg::REQ_TICK,    32'd610,  8'd0,   1'b0, 1'b1,
                    bbs_pkg::LINK_CONNECTED);
        drive_event(bbs_pkg::REQ_TICK,    32'd615,  8'd0,   1'b0, 1'b1, 3'd3);
        drive_event(bbs_pkg::REQ_TICK,    32'd620,  8'd0,   1'b0, 1'b1,
                    bbs_pkg::LINK_CONNECTED);
        drive_event(bbs_pkg::REQ_TICK,    32'd650,  8'd0,   1'b0, 1'b0,
                    bbs_pkg::LINK_CONNECTED);
        drive_event(bbs_pkg::REQ_TICK,    32'd5700, 8'd0,   1'b0, 1'b1,
                    bbs_pkg::LINK_CONNECTED);
        drive_event(bbs_pkg::REQ_TICK,    32'd5710, 8'd7,   1'b0, 1'b1,
                    bbs_pkg::LINK_CONNECTED);
        drive_event(bbs_pkg::REQ_TICK,    32'd5800, 8'd7,   1'b0, 1'b1,
                    bbs_pkg::LINK_CONNECTED);
        drive_event(bbs_pkg::REQ_TICK,    32'd70000, 8'd7,  1'b0, 1'b1,
                    bbs_pkg::LINK_CONNECTED);
        drive_event(bbs_pkg::REQ_TICK,    32'hFFFF_FFFF, 8'd255, 1'b1, 1'b1, 3'd7);
        drive_event(bbs_pkg::REQ_PRESS,   32'hFFFF_FFFF, 8'd255, 1'b1, 1'b1, 3'd7);
        drive_event(bbs_pkg::REQ_RELEASE, 32'hFFFF_FFFF, 8'd255, 1'b1, 1'b1, 3'd7);
        drain();

        // short intervals, with a long result hold-off and a full pause midway
        set_config(32'd2000, 32'd5, 32'd30, 32'd120, 32'd8,
                   16'($urandom), 16'($urandom), 16'($urandom));
        clock_ms = 32'd1000;
        hold_request = 1;
        run_random(100, 20);
        drain();
        run_random(100, 20);
        drain();

        // activity window and code bases at their top, other limits at zero, timer near wrap
        set_config(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0,
                   16'hFFFF, 16'hFFFF, 16'hFFFF);
        clock_ms = 32'hFFFF_FF00;
        run_random(120, 4);
        drain();

        // every register at zero
        set_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0);
        run_random(40, 10);
        drain();

        for (int p = 0; p < 3; p++) begin
            set_config($urandom_range(0, 5000), $urandom_range(0, 100),
                       $urandom_range(0, 400), $urandom_range(0, 2000),
                       ($urandom_range(0, 9) < 7) ? 32'($urandom_range(0, 50)) : $urandom,
                       16'($urandom), 16'($urandom), 16'($urandom));
            run_random(80, 60);
            drain();
        end

        // held-key count pinned at the top, then walked back to zero
        set_config(32'd100000, 32'd0, 32'd0, 32'd0, 32'd3,
                   16'($urandom), 16'($urandom), 16'($urandom));
        clock_ms = 32'd5000;
        drive_event(bbs_pkg::REQ_SAMPLE, clock_ms, 8'd80, 1'b0, 1'b1,
                    bbs_pkg::LINK_CONNECTED);
        for (int k = 0; k < 257; k++) begin
            clock_ms = clock_ms + 1;
            drive_event(bbs_pkg::REQ_PRESS, clock_ms, 8'd80, 1'b0, 1'b1,
                        bbs_pkg::LINK_CONNECTED);
        end
        for (int k = 0; k < 254; k++) begin
            clock_ms = clock_ms + 1;
            drive_event(bbs_pkg::REQ_RELEASE, clock_ms, 8'd80, 1'b0, 1'b1,
                        bbs_pkg::LINK_CONNECTED);
        end
        clock_ms = clock_ms + 5;
        drive_event(bbs_pkg::REQ_TICK, clock_ms, 8'd80, 1'b0, 1'b1,
                    bbs_pkg::LINK_CONNECTED);
        clock_ms = clock_ms + 1;
        drive_event(bbs_pkg::REQ_RELEASE, clock_ms, 8'd80, 1'b0, 1'b1,
                    bbs_pkg::LINK_CONNECTED);
        for (int k = 0; k < 3; k++) begin
            clock_ms = clock_ms + 5;
            drive_event(bbs_pkg::REQ_TICK, clock_ms, 8'd81, 1'b1, 1'b1,
                        bbs_pkg::LINK_CONNECTED);
        end
        drain();

        $display("run covered %0d events and %0d register writes over eight settings",
                 items_sent, cfg_writes);
        $display("checked %0d beacon words and %0d release words, %0d mismatches",
                 tracker.beacons, tracker.releases, tracker.errors);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/bbs_pkg.sv
rtl/bbs_front.sv
rtl/bbs_queue.sv
rtl/bbs_back.sv
rtl/battery_beacon_scheduler.sv
bench/tb.sv
